FILE: hdl/pale_pkg.sv
// Package for the positional array list engine.
// Holds the beat structs, operation and status codes, and the cell command.
// No dependencies.
package pale_pkg;

  localparam int unsigned ElemW  = 32;
  localparam int unsigned PosW   = 7;
  localparam int unsigned IndexW = 6;
  localparam int unsigned CountW = 7;
  localparam int unsigned MaxEmit = 64;

  typedef enum logic [2:0] {
    FN_CLEAR    = 3'd0,
    FN_APPEND   = 3'd1,
    FN_INSERT   = 3'd2,
    FN_DELETE   = 3'd3,
    FN_UPDATE   = 3'd4,
    FN_TRAVERSE = 3'd5,
    FN_SEARCH   = 3'd6
  } func_e;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_NOT_FOUND = 3'd1,
    STAT_BAD_POS   = 3'd2,
    STAT_FULL      = 3'd3,
    STAT_EMPTY     = 3'd4
  } status_e;

  typedef enum logic [0:0] {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } state_e;

  typedef enum logic [2:0] {
    CO_HOLD   = 3'd0,
    CO_WRITE  = 3'd1,
    CO_INSERT = 3'd2,
    CO_DELETE = 3'd3,
    CO_ROTATE = 3'd4
  } cell_op_e;

  typedef struct packed {
    func_e                    func;
    logic [PosW-1:0]          position;
    logic signed [ElemW-1:0]  value;
  } req_t;

  typedef struct packed {
    status_e                  status;
    logic signed [ElemW-1:0]  element;
    logic [IndexW-1:0]        index;
    logic [CountW-1:0]        count;
    logic                     last;
  } res_t;

  typedef struct packed {
    cell_op_e          op;
    logic [ElemW-1:0]  value;
  } cell_cmd_t;

endpackage

FILE: hdl/pale_cell.sv
// One list entry of the cell chain.
// Loads from its left or right neighbor, from the head cell or from the
// broadcast value, as the command and its own index decide. Uses pale_pkg.
module pale_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned XW  = 7
) (
  input  logic                        clk_i,
  input  pale_pkg::cell_cmd_t         cmd_i,
  input  logic [XW-1:0]               pos_i,
  input  logic [XW-1:0]               cnt_i,
  input  logic [pale_pkg::ElemW-1:0]  left_i,
  input  logic [pale_pkg::ElemW-1:0]  right_i,
  input  logic [pale_pkg::ElemW-1:0]  head_i,
  output logic [pale_pkg::ElemW-1:0]  value_o
);

  localparam logic [XW-1:0] MyIdx  = XW'(IDX);
  localparam logic [XW-1:0] MyIdx1 = XW'(IDX + 1);

  logic [pale_pkg::ElemW-1:0] value_q, value_d;

  always_comb begin
    value_d = value_q;
    case (cmd_i.op)
      pale_pkg::CO_WRITE: begin
        if (MyIdx == pos_i) value_d = cmd_i.value;
      end
      pale_pkg::CO_INSERT: begin
        if (MyIdx == pos_i) value_d = cmd_i.value;
        else if (MyIdx > pos_i) value_d = left_i;
      end
      pale_pkg::CO_DELETE: begin
        if (MyIdx >= pos_i) value_d = right_i;
      end
      pale_pkg::CO_ROTATE: begin
        // the tail of the live prefix wraps around to take the head
        if (MyIdx1 == cnt_i) value_d = head_i;
        else if (MyIdx1 < cnt_i) value_d = right_i;
      end
      default: value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

FILE: hdl/pale_outq.sv
// Two-entry result queue between the engine and the output channel.
// Lets the engine take a new item while one result beat waits. Uses pale_pkg.
module pale_outq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  pale_pkg::res_t  data_i,
  output logic            space_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output pale_pkg::res_t  out_o
);

  pale_pkg::res_t slot0_q, slot0_d, slot1_q, slot1_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           pop;
  logic [1:0]     wr_idx;

  always_comb begin
    pop     = (cnt_q != 2'd0) && !out_stall_i;
    wr_idx  = cnt_q - {1'b0, pop};
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    if (pop) slot0_d = slot1_q;
    if (push_i) begin
      if (wr_idx == 2'd0) slot0_d = data_i;
      else slot1_d = data_i;
    end
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

  assign space_o     = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_o       = slot0_q;

  overflow_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> cnt_q != 2'd2)
    else $error("result pushed into a full queue");

endmodule

FILE: hdl/positional_array_list_engine.sv
// Top level of the positional array list engine: a chain of list cells, a
// small sequencer for traverse and search, and a two-entry result queue.
// Uses pale_pkg, pale_cell and pale_outq.
//
//   channel  dir  handshake                  beat
//   in       in   in_valid_i / in_stall_o    pale_pkg::req_t
//   out      out  out_valid_o / out_stall_i  pale_pkg::res_t
//
// Append, insert, delete and update shift or load the cells in parallel, and
// clear only empties the count. Traverse and search rotate the live prefix
// through the head cell, one entry a cycle; an empty list starts no rotation.
// A stalled output holds the rotation while a result beat cannot be queued.
// Reset empties the list and the queue; cell contents are not cleared.
module positional_array_list_engine #(
  parameter int unsigned DEPTH = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  pale_pkg::req_t  in_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output pale_pkg::res_t  out_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned XW = (CW > pale_pkg::PosW) ? CW : pale_pkg::PosW;

  pale_pkg::state_e     state_q, state_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [CW-1:0]        k_q, k_d;
  logic [XW-1:0]        emit_q, emit_d;
  logic                 trav_q, trav_d;
  logic                 found_q, found_d;
  logic [pale_pkg::ElemW-1:0] key_q, key_d;
  logic [pale_pkg::ElemW-1:0] fval_q, fval_d;
  logic [CW-1:0]        fidx_q, fidx_d;

  pale_pkg::cell_cmd_t  cmd;
  logic [XW-1:0]        cell_pos;
  logic [XW-1:0]        cnt_x;
  logic [XW-1:0]        pos_x;
  logic [XW-1:0]        k1_x;
  logic [pale_pkg::ElemW-1:0] cell_val [DEPTH];
  logic [pale_pkg::ElemW-1:0] head;

  logic                 in_acc;
  logic                 start_scan;
  logic                 scan_done;
  logic                 push;
  logic                 space;
  pale_pkg::res_t       res;
  logic                 hit;

  assign cnt_x  = XW'(cnt_q);
  assign pos_x  = XW'(in_i.position);
  assign k1_x   = XW'(k_q) + XW'(1);
  assign head   = cell_val[0];
  assign hit    = (head == key_q);
  assign in_acc = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != pale_pkg::S_IDLE) || !space;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pale_pkg::S_IDLE: if (start_scan) state_d = pale_pkg::S_SCAN;
      pale_pkg::S_SCAN: if (scan_done) state_d = pale_pkg::S_IDLE;
      default: state_d = pale_pkg::S_IDLE;
    endcase
  end

  // datapath and results
  always_comb begin
    cnt_d      = cnt_q;
    k_d        = k_q;
    emit_d     = emit_q;
    trav_d     = trav_q;
    found_d    = found_q;
    key_d      = key_q;
    fval_d     = fval_q;
    fidx_d     = fidx_q;
    cmd.op     = pale_pkg::CO_HOLD;
    cmd.value  = in_i.value;
    cell_pos   = pos_x;
    start_scan = 1'b0;
    scan_done  = 1'b0;
    push       = 1'b0;
    res.status  = pale_pkg::STAT_OK;
    res.element = '0;
    res.index   = '0;
    res.last    = 1'b1;

    case (state_q)
      pale_pkg::S_IDLE: begin
        if (in_acc) begin
          push = 1'b1;
          case (in_i.func)
            pale_pkg::FN_CLEAR: cnt_d = '0;
            pale_pkg::FN_APPEND: begin
              if (cnt_x == XW'(DEPTH)) begin
                res.status = pale_pkg::STAT_FULL;
              end else begin
                cmd.op   = pale_pkg::CO_WRITE;
                cell_pos = cnt_x;
                cnt_d    = cnt_q + CW'(1);
              end
            end
            pale_pkg::FN_INSERT: begin
              if (cnt_x == XW'(DEPTH)) begin
                res.status = pale_pkg::STAT_FULL;
              end else if (pos_x > cnt_x) begin
                res.status = pale_pkg::STAT_BAD_POS;
              end else begin
                cmd.op = pale_pkg::CO_INSERT;
                cnt_d  = cnt_q + CW'(1);
              end
            end
            pale_pkg::FN_DELETE: begin
              if (cnt_q == '0) begin
                res.status = pale_pkg::STAT_EMPTY;
              end else if (pos_x >= cnt_x) begin
                res.status = pale_pkg::STAT_BAD_POS;
              end else begin
                cmd.op = pale_pkg::CO_DELETE;
                cnt_d  = cnt_q - CW'(1);
              end
            end
            pale_pkg::FN_UPDATE: begin
              if (cnt_q == '0) begin
                res.status = pale_pkg::STAT_EMPTY;
              end else if (pos_x >= cnt_x) begin
                res.status = pale_pkg::STAT_BAD_POS;
              end else begin
                cmd.op = pale_pkg::CO_WRITE;
              end
            end
            pale_pkg::FN_TRAVERSE: begin
              if (cnt_q == '0) begin
                res.status = pale_pkg::STAT_EMPTY;
              end else begin
                push       = 1'b0;
                start_scan = 1'b1;
                trav_d     = 1'b1;
                emit_d     = (cnt_x > XW'(pale_pkg::MaxEmit)) ?
                             XW'(pale_pkg::MaxEmit) : cnt_x;
              end
            end
            pale_pkg::FN_SEARCH: begin
              if (cnt_q == '0) begin
                res.status = pale_pkg::STAT_NOT_FOUND;
              end else begin
                push       = 1'b0;
                start_scan = 1'b1;
                trav_d     = 1'b0;
                key_d      = in_i.value;
              end
            end
            default: push = 1'b0;
          endcase
          k_d     = '0;
          found_d = 1'b0;
        end
      end
      pale_pkg::S_SCAN: begin
        if (trav_q) begin
          push        = (XW'(k_q) < XW'(pale_pkg::MaxEmit));
          res.element = head;
          res.index   = pale_pkg::IndexW'(k_q);
          res.last    = (k1_x == emit_q);
        end else begin
          push = (k1_x == cnt_x);
          if (found_q) begin
            res.element = fval_q;
            res.index   = pale_pkg::IndexW'(fidx_q);
          end else if (hit) begin
            res.element = head;
            res.index   = pale_pkg::IndexW'(k_q);
          end else begin
            res.status  = pale_pkg::STAT_NOT_FOUND;
          end
        end
        // hold the rotation while a beat cannot be queued
        if (!push || space) begin
          cmd.op = pale_pkg::CO_ROTATE;
          k_d    = k_q + CW'(1);
          if (!trav_q && hit && !found_q) begin
            found_d = 1'b1;
            fval_d  = head;
            fidx_d  = k_q;
          end
          scan_done = (k1_x == cnt_x);
        end else begin
          push = 1'b0;
        end
      end
      default: ;
    endcase
    res.count = pale_pkg::CountW'(cnt_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pale_pkg::S_IDLE;
      cnt_q   <= '0;
      k_q     <= '0;
      trav_q  <= 1'b0;
      found_q <= 1'b0;
      emit_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
      trav_q  <= trav_d;
      found_q <= found_d;
      emit_q  <= emit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    fval_q <= fval_d;
    fidx_q <= fidx_d;
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [pale_pkg::ElemW-1:0] left, right;
    if (g == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = cell_val[g-1];
    end
    if (g == DEPTH - 1) begin : g_lastc
      assign right = cell_val[g];
    end else begin : g_mid_r
      assign right = cell_val[g+1];
    end
    pale_cell #(
      .IDX (g),
      .XW  (XW)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .pos_i   (cell_pos),
      .cnt_i   (cnt_x),
      .left_i  (left),
      .right_i (right),
      .head_i  (head),
      .value_o (cell_val[g])
    );
  end

  pale_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .data_i      (res),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

  count_range_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    XW'(cnt_q) <= XW'(DEPTH))
    else $error("element count above depth");

  scan_nonempty_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == pale_pkg::S_SCAN |-> cnt_q != '0 && XW'(k_q) < cnt_x)
    else $error("scan beyond the live prefix");

  scan_count_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == pale_pkg::S_SCAN |=> $stable(cnt_q))
    else $error("count changed during a scan");

  push_space_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> space)
    else $error("result beat pushed without queue space");

endmodule

FILE: bench/pale_list_checker.sv
// Result checker for the positional array list engine.
// Mirrors the list from accepted request beats, queues the expected result
// beats and compares every accepted result beat field by field. Uses pale_pkg.
module pale_list_checker #(
  parameter int unsigned DEPTH = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  input  logic            req_stall_i,
  input  pale_pkg::req_t  req_i,
  input  logic            res_valid_i,
  input  logic            res_stall_i,
  input  pale_pkg::res_t  res_i,
  output int              mismatches_o,
  output int              outstanding_o
);

  logic signed [pale_pkg::ElemW-1:0] entries [DEPTH];
  int unsigned                       entry_count;
  pale_pkg::res_t                    expected_results [$];
  pale_pkg::res_t                    want;
  int                                fail_total;

  // Apply one request to the mirrored list and queue the result beats it causes.
  task automatic apply_list_op(input pale_pkg::req_t beat);
    pale_pkg::res_t r;
    int unsigned    n;
    int unsigned    pos;
    int unsigned    emit;
    int unsigned    i;
    n   = entry_count;
    pos = beat.position;
    r        = '0;
    r.status = pale_pkg::STAT_OK;
    r.last   = 1'b1;
    case (beat.func)
      pale_pkg::FN_CLEAR: entry_count = 0;
      pale_pkg::FN_APPEND: begin
        if (n >= DEPTH) begin
          r.status = pale_pkg::STAT_FULL;
        end else begin
          entries[n]  = beat.value;
          entry_count = n + 1;
        end
      end
      pale_pkg::FN_INSERT: begin
        if (n >= DEPTH) begin
          r.status = pale_pkg::STAT_FULL;
        end else if (pos > n) begin
          r.status = pale_pkg::STAT_BAD_POS;
        end else begin
          for (i = n; i > pos; i--) entries[i] = entries[i-1];
          entries[pos] = beat.value;
          entry_count  = n + 1;
        end
      end
      pale_pkg::FN_DELETE: begin
        if (n == 0) begin
          r.status = pale_pkg::STAT_EMPTY;
        end else if (pos >= n) begin
          r.status = pale_pkg::STAT_BAD_POS;
        end else begin
          for (i = pos; i + 1 < n; i++) entries[i] = entries[i+1];
          entry_count = n - 1;
        end
      end
      pale_pkg::FN_UPDATE: begin
        if (n == 0) begin
          r.status = pale_pkg::STAT_EMPTY;
        end else if (pos >= n) begin
          r.status = pale_pkg::STAT_BAD_POS;
        end else begin
          entries[pos] = beat.value;
        end
      end
      pale_pkg::FN_TRAVERSE: begin
        if (n == 0) begin
          r.status = pale_pkg::STAT_EMPTY;
        end else begin
          emit = (n > pale_pkg::MaxEmit) ? pale_pkg::MaxEmit : n;
          for (i = 0; i < emit; i++) begin
            r.element = entries[i];
            r.index   = i[pale_pkg::IndexW-1:0];
            r.count   = n[pale_pkg::CountW-1:0];
            r.last    = (i + 1 == emit);
            expected_results.push_back(r);
          end
          return;
        end
      end
      pale_pkg::FN_SEARCH: begin
        r.status = pale_pkg::STAT_NOT_FOUND;
        for (i = 0; i < n; i++) begin
          if (entries[i] == beat.value) begin
            r.status  = pale_pkg::STAT_OK;
            r.element = entries[i];
            r.index   = i[pale_pkg::IndexW-1:0];
            break;
          end
        end
      end
      default: return;  // unused code: no result, list untouched
    endcase
    r.count = entry_count[pale_pkg::CountW-1:0];
    expected_results.push_back(r);
  endtask

  task automatic compare_field(input string field, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s mismatch: expected %0h, actual %0h", field, exp_val, act_val);
      fail_total++;
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      entry_count = 0;
      fail_total  = 0;
      expected_results.delete();
    end else begin
      // Push before pop so a same-edge result still finds its expectation.
      if (req_valid_i && !req_stall_i) apply_list_op(req_i);
      if (res_valid_i && !res_stall_i) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result beat: status %0d element %0h index %0d count %0d",
                 res_i.status, res_i.element, res_i.index, res_i.count);
          fail_total++;
        end else begin
          want = expected_results.pop_front();
          compare_field("status", 32'(want.status), 32'(res_i.status));
          compare_field("element", want.element, res_i.element);
          compare_field("index", 32'(want.index), 32'(res_i.index));
          compare_field("count", 32'(want.count), 32'(res_i.count));
          compare_field("last", 32'(want.last), 32'(res_i.last));
        end
      end
    end
    mismatches_o  <= fail_total;
    outstanding_o <= expected_results.size();
  end

endmodule

FILE: bench/tb_top.sv
// Testbench top for the positional array list engine.
// Builds the request stream, drives both channels with random gaps and stalls,
// and gives the verdict. Uses pale_pkg and pale_list_checker.
module tb_top;

  localparam int unsigned ListDepth   = 64;
  localparam int unsigned ItemTarget  = 155;
  localparam int unsigned DrainCycles = 100;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned HoldCycles  = 250;
  localparam logic [2:0]  FN_UNUSED   = 3'd7;

  logic           clk       = 1'b0;
  logic           rst_n     = 1'b0;
  logic           req_valid = 1'b0;
  logic           req_stall;
  pale_pkg::req_t req_beat  = '0;
  logic           res_valid;
  logic           res_stall = 1'b0;
  pale_pkg::res_t res_beat;

  int             mismatches;
  int             outstanding;
  pale_pkg::req_t op_q [$];
  int unsigned plan_len   = 0;
  int unsigned planned    = 0;
  int unsigned issued     = 0;
  int unsigned hold_left  = 0;
  bit          hold_done  = 1'b0;
  bit          all_sent   = 1'b0;
  int unsigned cycle_count = 0;
  logic [31:0] value_pool [8];
  logic        quiet;
  logic        hold_active;

  always #10 clk = ~clk;

  positional_array_list_engine #(
    .DEPTH(ListDepth)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (req_valid),
    .in_stall_o (req_stall),
    .in_i       (req_beat),
    .out_valid_o(res_valid),
    .out_stall_i(res_stall),
    .out_o      (res_beat)
  );

  pale_list_checker #(
    .DEPTH(ListDepth)
  ) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .req_valid_i  (req_valid),
    .req_stall_i  (req_stall),
    .req_i        (req_beat),
    .res_valid_i  (res_valid),
    .res_stall_i  (res_stall),
    .res_i        (res_beat),
    .mismatches_o (mismatches),
    .outstanding_o(outstanding)
  );

  // No gaps and no stalls on either side for a stretch in the middle.
  assign quiet       = (issued >= 140) && (issued < 190);
  assign hold_active = (hold_left != 0);

  // Queue one request and track the list length it leaves behind.
  task automatic push_op(input logic [2:0] code, input int unsigned pos,
                         input logic [31:0] val);
    pale_pkg::req_t beat;
    beat.func     = pale_pkg::func_e'(code);
    beat.position = pos[pale_pkg::PosW-1:0];
    beat.value    = val;
    op_q.push_back(beat);
    if (code != FN_UNUSED) planned++;
    case (code)
      pale_pkg::FN_CLEAR:  plan_len = 0;
      pale_pkg::FN_APPEND: if (plan_len < ListDepth) plan_len++;
      pale_pkg::FN_INSERT: if (plan_len < ListDepth && pos <= plan_len) plan_len++;
      pale_pkg::FN_DELETE: if (plan_len > 0 && pos < plan_len) plan_len--;
      default: ;
    endcase
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      3, 4, 5: return value_pool[$urandom_range(7)];
      default: return $urandom;
    endcase
  endfunction

  function automatic int unsigned live_pos();
    return (plan_len == 0) ? 0 : $urandom_range(plan_len - 1);
  endfunction

  task automatic push_random_op(input bit shrink);
    int unsigned roll;
    int unsigned grow_w;
    int unsigned drop_w;
    bit          bad;
    roll   = $urandom_range(99);
    grow_w = shrink ? 8 : 20;
    drop_w = shrink ? 39 : 15;
    bad    = ($urandom_range(9) == 0);
    if (roll < 3)
      push_op(FN_UNUSED, $urandom_range(127), $urandom);
    else if (roll < 3 + grow_w)
      push_op(pale_pkg::FN_APPEND, $urandom_range(127), pick_value());
    else if (roll < 3 + 2 * grow_w)
      push_op(pale_pkg::FN_INSERT, bad ? $urandom_range(127) : $urandom_range(plan_len),
              pick_value());
    else if (roll < 3 + 2 * grow_w + drop_w)
      push_op(pale_pkg::FN_DELETE, bad ? $urandom_range(127) : live_pos(), $urandom);
    else if (roll < 73)
      push_op(pale_pkg::FN_UPDATE, bad ? $urandom_range(127) : live_pos(), pick_value());
    else if (roll < 88)
      push_op(pale_pkg::FN_SEARCH, $urandom_range(127),
              ($urandom_range(3) != 0) ? value_pool[$urandom_range(7)] : pick_value());
    else if (roll < 98)
      push_op(pale_pkg::FN_TRAVERSE, $urandom_range(127), $urandom);
    else
      push_op(pale_pkg::FN_CLEAR, $urandom_range(127), $urandom);
  endtask

  initial begin
    for (int k = 0; k < 8; k++) value_pool[k] = $urandom;

    // Directed: empty list, edges of every position check, duplicates, extremes.
    push_op(pale_pkg::FN_TRAVERSE, 0, 0);
    push_op(pale_pkg::FN_DELETE, 0, 0);
    push_op(pale_pkg::FN_UPDATE, 0, 7);
    push_op(pale_pkg::FN_SEARCH, 0, 0);
    push_op(pale_pkg::FN_INSERT, 1, 9);
    push_op(pale_pkg::FN_INSERT, 0, 32'h8000_0000);
    push_op(pale_pkg::FN_APPEND, 0, 32'h7FFF_FFFF);
    push_op(pale_pkg::FN_APPEND, 0, 32'h0);
    push_op(pale_pkg::FN_INSERT, 1, 32'hFFFF_FFFF);
    push_op(pale_pkg::FN_INSERT, plan_len, 5);
    push_op(pale_pkg::FN_INSERT, plan_len + 1, 11);
    push_op(pale_pkg::FN_APPEND, 0, 32'h7FFF_FFFF);
    push_op(pale_pkg::FN_SEARCH, 0, 32'h7FFF_FFFF);
    push_op(pale_pkg::FN_SEARCH, 0, 5);
    push_op(pale_pkg::FN_SEARCH, 0, 32'h1234_5678);
    push_op(pale_pkg::FN_UPDATE, 0, 32'h5555_5555);
    push_op(pale_pkg::FN_UPDATE, plan_len, 3);
    push_op(pale_pkg::FN_UPDATE, 127, 3);
    push_op(pale_pkg::FN_DELETE, plan_len, 0);
    push_op(pale_pkg::FN_DELETE, 0, 0);
    push_op(pale_pkg::FN_DELETE, plan_len - 1, 0);
    push_op(FN_UNUSED, 7'h55, 32'hAAAA_AAAA);
    push_op(pale_pkg::FN_TRAVERSE, 0, 0);
    push_op(pale_pkg::FN_CLEAR, 0, 0);
    push_op(pale_pkg::FN_TRAVERSE, 0, 0);
    push_op(pale_pkg::FN_SEARCH, 0, 0);

    // Fill to capacity, then hit the full list from every side.
    while (plan_len < ListDepth) begin
      if ($urandom_range(1) == 0)
        push_op(pale_pkg::FN_APPEND, $urandom_range(127), pick_value());
      else
        push_op(pale_pkg::FN_INSERT, $urandom_range(plan_len), pick_value());
    end
    push_op(pale_pkg::FN_APPEND, 0, $urandom);
    push_op(pale_pkg::FN_INSERT, $urandom_range(127), $urandom);
    push_op(pale_pkg::FN_TRAVERSE, 0, 0);
    push_op(pale_pkg::FN_SEARCH, 0, value_pool[0]);
    push_op(pale_pkg::FN_UPDATE, ListDepth - 1, 32'hFFFF_FFFF);
    push_op(pale_pkg::FN_UPDATE, ListDepth, 1);
    push_op(pale_pkg::FN_DELETE, ListDepth, 0);

    while (planned < ItemTarget) begin
      bit shrink;
      shrink = ($urandom_range(2) == 0);
      repeat ($urandom_range(30, 10)) push_random_op(shrink);
    end

    // Empty the list one delete at a time.
    while (plan_len > 0) push_op(pale_pkg::FN_DELETE, live_pos(), $urandom);
    push_op(pale_pkg::FN_DELETE, 0, 0);
    push_op(pale_pkg::FN_TRAVERSE, 0, 0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    wait (all_sent);
    while (outstanding != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Request side: advance on accept or when idle, hold while stalled.
  always @(posedge clk) begin
    if (rst_n && (!req_valid || !req_stall)) begin
      if (op_q.size() == 0) begin
        req_valid <= 1'b0;
        all_sent  <= 1'b1;
      end else if (!quiet && !hold_active && $urandom_range(99) < 33) begin
        req_valid <= 1'b0;
      end else begin
        req_beat  <= op_q.pop_front();
        req_valid <= 1'b1;
        issued    <= issued + 1;
      end
    end
  end

  // Result side: random stalls, plus one long hold-off to back the block up.
  always @(posedge clk) begin
    if (!rst_n) begin
      res_stall <= 1'b0;
    end else if (hold_left != 0) begin
      res_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && issued >= 70) begin
      res_stall <= 1'b1;
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end else begin
      res_stall <= !quiet && ($urandom_range(99) < 33);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

endmodule
